// ===== src/pcc_pkg.sv =====
// Shared types and constants for the polygon point containment block.
// No dependencies.
`default_nettype none

package pcc_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int EXTRA_BITS     = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_RESOLVE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      VERDICT_OUTSIDE   = 2'd0,
      VERDICT_INSIDE    = 2'd1,
      VERDICT_ON_EDGE   = 2'd2,
      VERDICT_ON_VERTEX = 2'd3
   } verdict_type;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

endpackage

`default_nettype wire

// ===== src/polygon_point_containment.sv =====
// A vertex item that forms no edge goes from idle to finish; an edge adds setup once
// per axis pass, then multiply, the bit-serial restoring divider and resolve for each
// pass whose line crosses it, one quotient bit per cycle.
// Throughput: one item at a time; the next is accepted once the block is back in idle.
// Reset: synchronous, active high; clears control state, the held query point and
// the crossing flags. The verdict register lets the next item in while a result waits.
`default_nettype none

module polygon_point_containment
   import pcc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_query_x,
   input  wire logic signed [COORD_BITS-1:0] req_query_y,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_x,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_y,
   input  wire logic                         req_first_vertex,
   input  wire logic                         req_last_vertex,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [1:0]                        rsp_verdict
);

   localparam int CB   = COORD_BITS;
   localparam int DW   = CB + 1;
   localparam int RW   = DW + 1;
   localparam int QW   = CB + 1 + EXTRA_BITS;
   localparam int CW   = CB + EXTRA_BITS + 2;
   localparam int NW   = 2 * DW + EXTRA_BITS;
   localparam int CNTW = $clog2(NW + 1);

   state_type               state_ff, state_in;
   logic signed [CB-1:0]    qx_ff, qx_in, qy_ff, qy_in;
   logic signed [CB-1:0]    px_ff, px_in, py_ff, py_in;
   logic signed [CB-1:0]    ex0_ff, ex0_in, ey0_ff, ey0_in;
   logic signed [CB-1:0]    ex1_ff, ex1_in, ey1_ff, ey1_in;
   logic                    have_prev_ff, have_prev_in;
   logic                    latched_ff, latched_in;
   verdict_type             lverdict_ff, lverdict_in;
   logic [3:0]              found_ff, found_in;
   logic [3:0]              faces_ff, faces_in;
   logic signed [CW-1:0]    near_ff [4];
   logic signed [CW-1:0]    near_in [4];
   logic                    last_ff, last_in;
   logic                    pass_ff, pass_in;
   logic [DW-1:0]           mag_ff, mag_in, a_ff, a_in, den_ff, den_in;
   logic                    neg_ff, neg_in;
   logic signed [CB-1:0]    base_ff, base_in;
   logic [NW-1:0]           dvd_ff, dvd_in;
   logic [RW-1:0]           rem_ff, rem_in;
   logic [QW-1:0]           quo_ff, quo_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   verdict_type             rsp_verdict_ff, rsp_verdict_in;

   logic signed [CB-1:0]    u0r, v0r, u1r, v1r, u0, v0, u1, v1, t, w, vlo, vhi;
   logic signed [DW-1:0]    dv, du, dt, dx, dy;
   logic [2*DW-1:0]         prod;
   logic [RW-1:0]           shifted;
   logic                    qbit;
   logic signed [CW-1:0]    basesc, wsc, qext, c;
   logic [CW-1:0]           rnz;
   logic                    exact, vhit;
   logic [1:0]              k;
   logic                    nearer, fout, enclosed;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   always_comb begin
      u0r = pass_ff ? ey0_ff : ex0_ff;
      v0r = pass_ff ? ex0_ff : ey0_ff;
      u1r = pass_ff ? ey1_ff : ex1_ff;
      v1r = pass_ff ? ex1_ff : ey1_ff;
      if (u1r < u0r) begin
         u0 = u1r; v0 = v1r; u1 = u0r; v1 = v0r;
      end else begin
         u0 = u0r; v0 = v0r; u1 = u1r; v1 = v1r;
      end
      t   = pass_ff ? qy_ff : qx_ff;
      w   = pass_ff ? qx_ff : qy_ff;
      vlo = (v0 < v1) ? v0 : v1;
      vhi = (v0 < v1) ? v1 : v0;
      dv  = DW'(v1) - DW'(v0);
      du  = DW'(u1) - DW'(u0);
      dt  = DW'(t) - DW'(u0);
      dx  = DW'(ex1_ff) - DW'(ex0_ff);
      dy  = DW'(ey1_ff) - DW'(ey0_ff);
      vhit = (qx_ff == ex0_ff && qy_ff == ey0_ff) || (qx_ff == ex1_ff && qy_ff == ey1_ff);

      prod    = mag_ff * a_ff;
      shifted = {rem_ff[RW-2:0], dvd_ff[NW-1]};
      qbit    = (shifted >= {1'b0, den_ff});

      basesc = CW'(base_ff) <<< EXTRA_BITS;
      wsc    = CW'(w) <<< EXTRA_BITS;
      qext   = $signed(CW'(quo_ff));
      rnz    = CW'(rem_ff != '0);
      exact  = (rem_ff == '0);
      if (neg_ff) begin
         c = basesc - qext - $signed(rnz);
      end else begin
         c = basesc + qext;
      end
      if (c >= wsc) begin
         k      = pass_ff ? DIR_RIGHT : DIR_UP;
         nearer = (c < near_ff[k]);
         fout   = pass_ff ? (dy > 0) : (dx < 0);
      end else begin
         k      = pass_ff ? DIR_LEFT : DIR_DOWN;
         nearer = (c > near_ff[k]);
         fout   = pass_ff ? (dy < 0) : (dx > 0);
      end
      enclosed = &(found_ff & faces_ff);
   end

   always_comb begin
      state_in       = state_ff;
      qx_in          = qx_ff;
      qy_in          = qy_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      ex0_in         = ex0_ff;
      ey0_in         = ey0_ff;
      ex1_in         = ex1_ff;
      ey1_in         = ey1_ff;
      have_prev_in   = have_prev_ff;
      latched_in     = latched_ff;
      lverdict_in    = lverdict_ff;
      found_in       = found_ff;
      faces_in       = faces_ff;
      near_in        = near_ff;
      last_in        = last_ff;
      pass_in        = pass_ff;
      mag_in         = mag_ff;
      a_in           = a_ff;
      den_in         = den_ff;
      neg_in         = neg_ff;
      base_in        = base_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ex0_in       = px_ff;
               ey0_in       = py_ff;
               ex1_in       = req_vertex_x;
               ey1_in       = req_vertex_y;
               px_in        = req_vertex_x;
               py_in        = req_vertex_y;
               last_in      = req_last_vertex;
               pass_in      = 1'b0;
               state_in     = ST_FINISH;
               if (req_first_vertex) begin
                  qx_in       = req_query_x;
                  qy_in       = req_query_y;
                  found_in    = '0;
                  faces_in    = '0;
                  latched_in  = 1'b0;
                  lverdict_in = VERDICT_OUTSIDE;
               end else if (have_prev_ff && !latched_ff) begin
                  state_in = ST_SETUP;
               end
               have_prev_in = 1'b1;
            end
         end
         ST_SETUP: begin
            if (!pass_ff && vhit) begin
               latched_in  = 1'b1;
               lverdict_in = VERDICT_ON_VERTEX;
               state_in    = ST_FINISH;
            end else if (u0 == u1) begin
               if (t == u0 && w > vlo && w < vhi) begin
                  latched_in  = 1'b1;
                  lverdict_in = VERDICT_ON_EDGE;
                  state_in    = ST_FINISH;
               end else begin
                  pass_in  = 1'b1;
                  state_in = pass_ff ? ST_FINISH : ST_SETUP;
               end
            end else if (t > u0 && t < u1) begin
               mag_in   = dv[DW-1] ? DW'(-dv) : DW'(dv);
               a_in     = dt;
               den_in   = du;
               neg_in   = dv[DW-1];
               base_in  = v0;
               state_in = ST_MUL;
            end else begin
               pass_in  = 1'b1;
               state_in = pass_ff ? ST_FINISH : ST_SETUP;
            end
         end
         ST_MUL: begin
            dvd_in   = {prod, {EXTRA_BITS{1'b0}}};
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = CNTW'(NW);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? (shifted - {1'b0, den_ff}) : shifted;
            quo_in = {quo_ff[QW-2:0], qbit};
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNTW'(1)) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (exact && c == wsc) begin
               latched_in  = 1'b1;
               lverdict_in = VERDICT_ON_EDGE;
               state_in    = ST_FINISH;
            end else begin
               if (!found_ff[k] || nearer) begin
                  found_in[k] = 1'b1;
                  near_in[k]  = c;
                  faces_in[k] = fout;
               end
               pass_in  = 1'b1;
               state_in = pass_ff ? ST_FINISH : ST_SETUP;
            end
         end
         ST_FINISH: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = latched_ff ? lverdict_ff :
                                (enclosed ? VERDICT_INSIDE : VERDICT_OUTSIDE);
               found_in       = '0;
               faces_in       = '0;
               latched_in     = 1'b0;
               lverdict_in    = VERDICT_OUTSIDE;
               have_prev_in   = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qx_ff        <= '0;
         qy_ff        <= '0;
         have_prev_ff <= 1'b0;
         latched_ff   <= 1'b0;
         lverdict_ff  <= VERDICT_OUTSIDE;
         found_ff     <= '0;
         faces_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qx_ff        <= qx_in;
         qy_ff        <= qy_in;
         have_prev_ff <= have_prev_in;
         latched_ff   <= latched_in;
         lverdict_ff  <= lverdict_in;
         found_ff     <= found_in;
         faces_ff     <= faces_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff          <= px_in;
      py_ff          <= py_in;
      ex0_ff         <= ex0_in;
      ey0_ff         <= ey0_in;
      ex1_ff         <= ex1_in;
      ey1_ff         <= ey1_in;
      near_ff        <= near_in;
      last_ff        <= last_in;
      pass_ff        <= pass_in;
      mag_ff         <= mag_in;
      a_ff           <= a_in;
      den_ff         <= den_in;
      neg_ff         <= neg_in;
      base_ff        <= base_in;
      dvd_ff         <= dvd_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

endmodule

`default_nettype wire

// ===== src/pcc_checker.sv =====
// Port-level checks for polygon_point_containment, bound to the top level.
// Depends on the top level's port list.
`default_nettype none

module pcc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_verdict
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict))
      else $error("result item dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted on consecutive cycles");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result item raised without work in flight");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear the result channel");

endmodule

bind polygon_point_containment pcc_checker u_pcc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_verdict (rsp_verdict)
);

`default_nettype wire
